### rtl/glmp_pkg.sv
// Shared constants and types for the grid longest monotone path block.
// Used by glmp_core and grid_longest_monotone_path; depends on nothing else.
package glmp_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 1024;

    localparam int DIM_W = 11;
    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int ROW_W = $clog2(MAX_HEIGHT);
    localparam int LEN_W = 11;
    localparam logic [LEN_W-1:0] LEN_MAX = {LEN_W{1'b1}};

    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_GRID_HEIGHT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH  = 2'd1;

    typedef struct packed {
        logic [DIM_W-1:0] height;
        logic [DIM_W-1:0] width;
    } t_dims;

    typedef struct packed {
        logic             valid;
        logic [LEN_W-1:0] value;
    } t_res;

    typedef struct packed {
        logic last_pending;
    } t_core_stat;

endpackage

### rtl/glmp_core.sv
// Row-buffer datapath: raster counters, column memory and cell update.
// Depends on glmp_pkg.
module glmp_core
    import glmp_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_accept,
    input  logic       i_is_wall,
    input  t_dims      i_dims,
    input  logic       i_restart,
    output t_res       o_res,
    output t_core_stat o_stat
);

    logic [LEN_W-1:0] r_mem [MAX_WIDTH];
    logic [LEN_W-1:0] r_rd_data;

    logic [COL_W-1:0] r_col, n_col;
    logic [ROW_W-1:0] r_row, n_row;
    logic             last_col, last_row;

    logic             r_s1_valid;
    logic             r_s1_wall;
    logic [COL_W-1:0] r_s1_col;
    logic             r_s1_first_row;
    logic             r_s1_last;
    logic             r_hit;
    logic [LEN_W-1:0] r_hit_val;
    logic [LEN_W-1:0] r_left;
    logic [LEN_W-1:0] r_best;

    logic [LEN_W-1:0] up, left, larger, cell_len, best_next;

    assign last_col = ({1'b0, r_col} == (i_dims.width - DIM_W'(1)));
    assign last_row = ({1'b0, r_row} == (i_dims.height - DIM_W'(1)));

    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if (i_accept) begin
            if (last_col) begin
                n_col = '0;
                n_row = last_row ? '0 : r_row + ROW_W'(1);
            end else begin
                n_col = r_col + COL_W'(1);
            end
        end
        if (i_restart) begin
            n_col = '0;
            n_row = '0;
        end
    end

    always_comb begin
        up     = r_s1_first_row ? '0 : (r_hit ? r_hit_val : r_rd_data);
        left   = (r_s1_col == '0) ? '0 : r_left;
        larger = (up > left) ? up : left;
        if (r_s1_wall) begin
            cell_len = '0;
        end else if (r_s1_first_row && r_s1_col == '0) begin
            cell_len = LEN_W'(1);
        end else if (larger == '0) begin
            cell_len = '0;
        end else if (larger == LEN_MAX) begin
            cell_len = LEN_MAX;
        end else begin
            cell_len = larger + LEN_W'(1);
        end
        best_next = (cell_len > r_best) ? cell_len : r_best;
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_rd_data <= r_mem[r_col];
        end
        if (r_s1_valid) begin
            r_mem[r_s1_col] <= cell_len;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col      <= '0;
            r_row      <= '0;
            r_s1_valid <= 1'b0;
            r_best     <= '0;
        end else begin
            r_col      <= n_col;
            r_row      <= n_row;
            r_s1_valid <= i_accept;
            if (i_restart) begin
                r_best <= '0;
            end else if (r_s1_valid) begin
                r_best <= r_s1_last ? '0 : best_next;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_s1_wall      <= i_is_wall;
            r_s1_col       <= r_col;
            r_s1_first_row <= (r_row == '0);
            r_s1_last      <= last_col && last_row;
            r_hit          <= r_s1_valid && (r_s1_col == r_col);
            r_hit_val      <= cell_len;
        end
        if (r_s1_valid) begin
            r_left <= cell_len;
        end
    end

    assign o_res.valid         = r_s1_valid && r_s1_last;
    assign o_res.value         = best_next;
    assign o_stat.last_pending = r_s1_valid && r_s1_last;

endmodule

### rtl/grid_longest_monotone_path.sv
// Takes grid cells in raster order, one beat per cell, and gives the number of
// cells on the longest right/down path from the top-left cell after the last
// cell. The block accepts one cell per clock cycle while the queue has room;
// the result is written into the queue from the stage-1 register after the
// last cell is accepted. The rate is set by the row buffer, a column memory
// with one read port and one write port, each used once per cycle, with a
// forwarding register for the one-column case. A four-beat output queue holds
// results until the sink takes them. No clearing pass follows reset: the first
// row of each grid ignores the row buffer. Depends on glmp_pkg and glmp_core.
module grid_longest_monotone_path
    import glmp_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_s_tvalid,
    output logic                 o_s_tready,
    input  logic [7:0]           i_s_tdata,   // [0] is_wall
    output logic                 o_m_tvalid,
    input  logic                 i_m_tready,
    output logic [15:0]          o_m_tdata,   // [10:0] longest_path
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [DIM_W-1:0]     i_cfg_data
);

    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = Q_PTR_W + 1;

    logic [DIM_W-1:0]   r_grid_height;
    logic [DIM_W-1:0]   r_grid_width;
    t_dims              dims;
    logic               cfg_write;
    logic               restart;
    logic               accept;
    t_res               res;
    t_core_stat         stat;

    logic [LEN_W-1:0]   r_queue [Q_DEPTH];
    logic [Q_PTR_W-1:0] r_wr_ptr;
    logic [Q_PTR_W-1:0] r_rd_ptr;
    logic [Q_CNT_W-1:0] r_occ;
    logic [Q_CNT_W:0]   committed;
    logic               pop;

    assign o_cfg_ready = 1'b1;
    assign cfg_write   = i_cfg_valid && o_cfg_ready;
    assign restart     = cfg_write &&
                         (i_cfg_index == REG_GRID_HEIGHT || i_cfg_index == REG_GRID_WIDTH);

    always_comb begin
        if (r_grid_height == '0) begin
            dims.height = DIM_W'(1);
        end else if (r_grid_height > DIM_W'(MAX_HEIGHT)) begin
            dims.height = DIM_W'(MAX_HEIGHT);
        end else begin
            dims.height = r_grid_height;
        end
        if (r_grid_width == '0) begin
            dims.width = DIM_W'(1);
        end else if (r_grid_width > DIM_W'(MAX_WIDTH)) begin
            dims.width = DIM_W'(MAX_WIDTH);
        end else begin
            dims.width = r_grid_width;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_height <= DIM_W'(MAX_HEIGHT);
            r_grid_width  <= DIM_W'(MAX_WIDTH);
        end else if (cfg_write) begin
            if (i_cfg_index == REG_GRID_HEIGHT) begin
                r_grid_height <= i_cfg_data;
            end
            if (i_cfg_index == REG_GRID_WIDTH) begin
                r_grid_width <= i_cfg_data;
            end
        end
    end

    assign committed  = {1'b0, r_occ} + (Q_CNT_W+1)'(stat.last_pending);
    assign o_s_tready = (committed < (Q_CNT_W+1)'(Q_DEPTH));
    assign accept     = i_s_tvalid && o_s_tready;

    glmp_core u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_accept  (accept),
        .i_is_wall (i_s_tdata[0]),
        .i_dims    (dims),
        .i_restart (restart),
        .o_res     (res),
        .o_stat    (stat)
    );

    assign o_m_tvalid = (r_occ != '0);
    assign o_m_tdata  = {{(16-LEN_W){1'b0}}, r_queue[r_rd_ptr]};
    assign pop        = o_m_tvalid && i_m_tready;

    always_ff @(posedge i_clk) begin
        if (res.valid) begin
            r_queue[r_wr_ptr] <= res.value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_occ    <= '0;
        end else begin
            if (res.valid) begin
                r_wr_ptr <= r_wr_ptr + Q_PTR_W'(1);
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + Q_PTR_W'(1);
            end
            r_occ <= r_occ + Q_CNT_W'(res.valid) - Q_CNT_W'(pop);
        end
    end

endmodule
